// ===== src/ritt_pkg.sv =====
// shared types, constants and the digit character table for the radix text converter
// no dependencies; used by every module under src
package ritt_pkg;

    localparam int VALUE_W       = 31;
    localparam int DIGIT_W       = 4;
    localparam int PAIR_W        = 2;
    localparam int FEED_W        = 32;
    localparam int STEPS         = FEED_W / PAIR_W;
    localparam int STEP_W        = $clog2(STEPS);
    localparam int RADIX_W       = 8;
    localparam int RADIX_LO_W    = 5;
    localparam int FW_W          = 5;
    localparam int CH_W          = 8;
    localparam int COUNT_W       = 4;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 16;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 8;
    localparam int MAX_WIDTH_DEF = 16;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 8'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
    localparam logic [FW_W-1:0]    FW_RESET    = 5'd10;

    localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIX       = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIELD_WIDTH = 1'b1;

    // step marker that travels along the cell row with each pair of value bits
    typedef struct packed {
        logic act;
        logic first;
        logic fin;
    } tok_t;

    function automatic logic [CH_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CH_W-1:0] c;
        case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            4'hF: c = 8'h46;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ===== src/ritt_cell.sv =====
// one digit cell of the conversion row: keeps one radix digit, takes two value bits'
// worth of carry from the cell below and hands its own carry upwards; uses ritt_pkg
module ritt_cell #(
    parameter int NC  = ritt_pkg::MAX_WIDTH_DEF - 1,
    parameter int IDX = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic [ritt_pkg::RADIX_LO_W-1:0]    radix_lo,
    input  ritt_pkg::tok_t                     tok_in,
    input  logic [ritt_pkg::PAIR_W-1:0]        carry_in,
    input  logic [NC*ritt_pkg::DIGIT_W-1:0]    res_in,
    output ritt_pkg::tok_t                     tok_out,
    output logic [ritt_pkg::PAIR_W-1:0]        carry_out,
    output logic [NC*ritt_pkg::DIGIT_W-1:0]    res_out
);

    ritt_pkg::tok_t                        tok_out_reg;
    logic [ritt_pkg::PAIR_W-1:0]           carry_out_reg;
    logic [NC*ritt_pkg::DIGIT_W-1:0]       res_out_reg;
    logic [ritt_pkg::DIGIT_W-1:0]          digit_reg;

    logic [ritt_pkg::DIGIT_W-1:0]          base;
    logic [6:0]                            t7;
    logic [6:0]                            r1;
    logic [6:0]                            r2;
    logic [6:0]                            r3;
    logic [6:0]                            rem;
    logic [ritt_pkg::PAIR_W-1:0]           q;
    logic [ritt_pkg::DIGIT_W-1:0]          digit_next;
    logic [NC*ritt_pkg::DIGIT_W-1:0]       res_next;

    // t = 4 * digit + carry, then t = q * radix + new digit with q below four
    always_comb begin
        base = tok_in.first ? '0 : digit_reg;
        t7   = {1'b0, base, carry_in};
        r1   = {2'b00, radix_lo};
        r2   = {r1[5:0], 1'b0};
        r3   = r2 + r1;
        if (t7 >= r3) begin
            q   = 2'd3;
            rem = t7 - r3;
        end else if (t7 >= r2) begin
            q   = 2'd2;
            rem = t7 - r2;
        end else if (t7 >= r1) begin
            q   = 2'd1;
            rem = t7 - r1;
        end else begin
            q   = 2'd0;
            rem = t7;
        end
        digit_next = rem[ritt_pkg::DIGIT_W-1:0];
        res_next   = res_in;
        if (tok_in.act && tok_in.fin) begin
            res_next[IDX*ritt_pkg::DIGIT_W +: ritt_pkg::DIGIT_W] = digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_out_reg <= '0;
        end else if (en) begin
            tok_out_reg <= tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            carry_out_reg <= q;
            res_out_reg   <= res_next;
            if (tok_in.act) begin
                digit_reg <= digit_next;
            end
        end
    end

    assign tok_out   = tok_out_reg;
    assign carry_out = carry_out_reg;
    assign res_out   = res_out_reg;

endmodule

// ===== src/ritt_emit.sv =====
// field formatter and character sender: takes the finished digit row, works out
// leading spaces, count and error, and sends one character per cycle unless stalled; uses ritt_pkg
module ritt_emit #(
    parameter int MAX_WIDTH = ritt_pkg::MAX_WIDTH_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic [ritt_pkg::RADIX_W-1:0]                radix,
    input  logic [ritt_pkg::FW_W-1:0]                   field_width,
    input  logic                                        cap_valid,
    input  logic [(MAX_WIDTH-1)*ritt_pkg::DIGIT_W-1:0]  cap_digits,
    input  logic                                        cap_ovf,
    output logic                                        cap_ready,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [ritt_pkg::M_TDATA_W-1:0]              m_tdata,
    output logic                                        m_tlast,
    output logic                                        m_tuser
);

    localparam int NC = MAX_WIDTH - 1;
    localparam int CW = $clog2(NC + 1);
    localparam int DW = ritt_pkg::DIGIT_W;

    logic                                pend_valid_reg;
    logic [ritt_pkg::FW_W-1:0]           pend_pos_reg;
    logic [NC*DW-1:0]                    pend_digits_reg;
    logic [NC-1:0]                       pend_show_reg;
    logic [ritt_pkg::FW_W-1:0]           pend_wl_reg;
    logic [ritt_pkg::COUNT_W-1:0]        pend_count_reg;
    logic                                pend_err_reg;
    logic                                pend_zw_reg;

    logic                                m_tvalid_reg;
    logic [ritt_pkg::CH_W-1:0]           m_ch_reg;
    logic                                m_chv_reg;
    logic                                m_last_reg;
    logic [ritt_pkg::COUNT_W-1:0]        m_cnt_reg;
    logic                                m_err_reg;

    logic                                cap_zw;
    logic [ritt_pkg::FW_W-1:0]           cap_wl;
    logic                                rad_ok;
    logic                                multi;
    logic [NC-1:0]                       nz;
    logic [NC:0]                         shown_ext;
    logic [NC-1:0]                       cap_show;
    logic [CW-1:0]                       cnt_sum;
    logic                                err_hit;
    logic                                cap_err;
    logic [ritt_pkg::COUNT_W-1:0]        cap_count;

    logic                                out_free;
    logic                                issue;
    logic                                pos_last;
    logic [DW-1:0]                       sel_d;
    logic                                sel_s;
    logic [ritt_pkg::CH_W-1:0]           ch_next;
    logic                                chv_next;
    logic [ritt_pkg::COUNT_W-1:0]        cnt_next;
    logic                                err_next;

    // capture side: a digit is shown while anything at or above it is non-zero
    always_comb begin
        cap_zw  = (field_width == '0);
        cap_wl  = (int'(field_width) > MAX_WIDTH) ? ritt_pkg::FW_W'(MAX_WIDTH) : field_width;
        rad_ok  = (radix >= ritt_pkg::RADIX_MIN) && (radix <= ritt_pkg::RADIX_MAX);
        multi   = (int'(cap_wl) >= 2);
        cnt_sum = '0;
        err_hit = 1'b0;
        for (int k = 0; k < NC; k++) begin
            nz[k] = (cap_digits[k*DW +: DW] != '0);
        end
        shown_ext[NC] = cap_ovf;
        for (int k = 0; k < NC; k++) begin
            shown_ext[k] = cap_ovf || (|(nz >> k));
        end
        for (int k = 0; k < NC; k++) begin
            cap_show[k] = shown_ext[k] && (k < int'(cap_wl) - 1) && rad_ok && multi;
            cnt_sum     = cnt_sum + CW'(cap_show[k]);
        end
        for (int k = 0; k <= NC; k++) begin
            if (k == int'(cap_wl) - 1) begin
                err_hit = shown_ext[k];
            end
        end
        cap_err   = cap_zw || (multi && (!rad_ok || err_hit));
        cap_count = cap_zw ? '0 : ritt_pkg::COUNT_W'(cnt_sum);
    end

    // send side
    always_comb begin
        sel_d = '0;
        sel_s = 1'b0;
        for (int k = 0; k < NC; k++) begin
            if (k == int'(pend_wl_reg) - 2 - int'(pend_pos_reg)) begin
                sel_d = pend_digits_reg[k*DW +: DW];
                sel_s = pend_show_reg[k];
            end
        end
        pos_last  = pend_zw_reg || (pend_pos_reg == pend_wl_reg - 1'b1);
        out_free  = !m_tvalid_reg || m_tready;
        issue     = pend_valid_reg && out_free;
        cap_ready = !pend_valid_reg || (issue && pos_last);
        if (pos_last) begin
            ch_next  = ritt_pkg::CHAR_NUL;
            chv_next = !pend_zw_reg;
            cnt_next = pend_count_reg;
            err_next = pend_err_reg;
        end else begin
            ch_next  = sel_s ? ritt_pkg::digit_char(sel_d) : ritt_pkg::CHAR_SPACE;
            chv_next = 1'b1;
            cnt_next = '0;
            err_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_pos_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (issue) begin
                m_tvalid_reg <= 1'b1;
            end else if (out_free) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cap_valid && cap_ready) begin
                pend_valid_reg <= 1'b1;
                pend_pos_reg   <= '0;
            end else if (issue && pos_last) begin
                pend_valid_reg <= 1'b0;
                pend_pos_reg   <= '0;
            end else if (issue) begin
                pend_pos_reg <= pend_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_valid && cap_ready) begin
            pend_digits_reg <= cap_digits;
            pend_show_reg   <= cap_show;
            pend_wl_reg     <= cap_wl;
            pend_count_reg  <= cap_count;
            pend_err_reg    <= cap_err;
            pend_zw_reg     <= cap_zw;
        end
        if (issue) begin
            m_ch_reg   <= ch_next;
            m_chv_reg  <= chv_next;
            m_last_reg <= pos_last;
            m_cnt_reg  <= cnt_next;
            m_err_reg  <= err_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_chv_reg;
    assign m_tdata  = {{(ritt_pkg::M_TDATA_W - ritt_pkg::CH_W - ritt_pkg::COUNT_W - 1){1'b0}},
                       m_err_reg, m_cnt_reg, m_ch_reg};

    a_capture_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_valid && cap_ready |=> pend_valid_reg && (pend_pos_reg == '0))
        else $error("captured row did not start at the first position");

    a_pos_in_field: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && !pend_zw_reg |-> pend_pos_reg < pend_wl_reg)
        else $error("send position ran past the field");

    a_empty_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_chv_reg |-> m_last_reg && m_err_reg)
        else $error("empty item not marked last with error");

endmodule

// ===== src/radix_integer_to_text.sv =====
// top level of the radix integer-to-text converter: input shifter, digit cell row,
// configuration registers and the formatter; uses ritt_pkg, ritt_cell and ritt_emit
//
// usage
// - s_ channel: one item is a 31-bit non-negative value in s_tdata[30:0]
// - m_ channel: per item, field_width characters (at most MAX_WIDTH) left to right
//   (spaces, digits, then a NUL marked by m_tlast); a zero field width gives one empty
//   item with m_tuser low. digit count and error are meaningful on the m_tlast item only
// - cfg port: cfg_we with cfg_addr 0 writes the radix, 1 the field width; write
//   only while the block is idle. reset puts both at 10
// - the value enters the cell row two bits a cycle while the row is not frozen, most
//   significant first, so an item occupies the input until its last pair is in; items
//   follow back to back, and the row holds several at once, skewed by one cell per cycle
// - after the first character of an item, the rest follow at one character per cycle
//   while the receiver keeps taking them
// - a stalled receiver first fills the one-item formatter buffer; when the row
//   then finishes another item the whole row and the input freeze until room
// - reset clears the item markers in the row, the buffer and the output valid;
//   no item is lost or repeated across a stall
module radix_integer_to_text #(
    parameter int MAX_WIDTH = ritt_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [ritt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ritt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ritt_pkg::S_TDATA_W-1:0]       s_tdata,   // [30:0] value, [31] zero
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ritt_pkg::M_TDATA_W-1:0]       m_tdata,   // [7:0] ch, [11:8] digit_count,
                                                            // [12] error, [15:13] zero
    output logic                                 m_tlast,   // last
    output logic                                 m_tuser    // ch_valid
);

    localparam int NC = MAX_WIDTH - 1;
    localparam int DW = ritt_pkg::DIGIT_W;

    // configuration
    logic [ritt_pkg::RADIX_W-1:0]       radix_reg;
    logic [ritt_pkg::FW_W-1:0]          fw_reg;

    // input shifter
    logic                               busy_reg;
    logic [ritt_pkg::STEP_W-1:0]        cnt_reg;
    logic [ritt_pkg::FEED_W-1:0]        sh_reg;

    // overflow out of the top cell, gathered over one item
    logic                               ovf_acc_reg;

    ritt_pkg::tok_t                     tok_l [0:NC];
    logic [ritt_pkg::PAIR_W-1:0]        car_l [0:NC];
    logic [NC*DW-1:0]                   res_l [0:NC];

    logic                               en;
    logic                               accept;
    logic                               feed_done;
    logic                               cap_due;
    logic                               cap_ready;
    logic                               cap_ovf;
    logic                               ovf_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= ritt_pkg::RADIX_RESET;
            fw_reg    <= ritt_pkg::FW_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                ritt_pkg::REG_RADIX:       radix_reg <= cfg_wdata;
                ritt_pkg::REG_FIELD_WIDTH: fw_reg    <= cfg_wdata[ritt_pkg::FW_W-1:0];
                default: ;
            endcase
        end
    end

    // the row moves as one; it only holds while a finished item waits for the formatter
    assign cap_due   = tok_l[NC].act && tok_l[NC].fin;
    assign en        = !(cap_due && !cap_ready);
    assign feed_done = (cnt_reg == ritt_pkg::STEP_W'(ritt_pkg::STEPS - 1));
    assign s_tready  = en && (!busy_reg || feed_done);
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (en && busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (feed_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sh_reg <= {{(ritt_pkg::FEED_W - ritt_pkg::VALUE_W){1'b0}},
                       s_tdata[ritt_pkg::VALUE_W-1:0]};
        end else if (en && busy_reg) begin
            sh_reg <= {sh_reg[ritt_pkg::FEED_W-ritt_pkg::PAIR_W-1:0], {ritt_pkg::PAIR_W{1'b0}}};
        end
    end

    // bottom of the row: next bit pair of the value, marked first and final step
    assign tok_l[0].act   = busy_reg;
    assign tok_l[0].first = (cnt_reg == '0);
    assign tok_l[0].fin   = feed_done;
    assign car_l[0]       = sh_reg[ritt_pkg::FEED_W-1 -: ritt_pkg::PAIR_W];
    assign res_l[0]       = '0;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        ritt_cell #(
            .NC  (NC),
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .radix_lo  (radix_reg[ritt_pkg::RADIX_LO_W-1:0]),
            .tok_in    (tok_l[i]),
            .carry_in  (car_l[i]),
            .res_in    (res_l[i]),
            .tok_out   (tok_l[i+1]),
            .carry_out (car_l[i+1]),
            .res_out   (res_l[i+1])
        );
    end

    // any carry leaving the top cell means the value needs more digits than the row
    assign ovf_base = tok_l[NC].first ? 1'b0 : ovf_acc_reg;
    assign cap_ovf  = ovf_base || (car_l[NC] != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_acc_reg <= 1'b0;
        end else if (en && tok_l[NC].act) begin
            ovf_acc_reg <= cap_ovf;
        end
    end

    ritt_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .radix       (radix_reg),
        .field_width (fw_reg),
        .cap_valid   (cap_due),
        .cap_digits  (res_l[NC]),
        .cap_ovf     (cap_ovf),
        .cap_ready   (cap_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    a_accept_starts_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && (cnt_reg == '0))
        else $error("accepted item did not start the shifter");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_due && !cap_ready |-> !s_tready)
        else $error("input taken while the cell row is frozen");

    a_stall_holds_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !en |=> $stable(cnt_reg) && $stable(sh_reg))
        else $error("shifter moved while the cell row is frozen");

endmodule

// ===== sim/text_field_checker.sv =====
`timescale 1ns / 1ps
// checker for the radix text converter: tracks register writes, predicts the text field
// of every accepted input item and compares each result item in order; uses ritt_pkg
module text_field_checker #(
    parameter int MAX_WIDTH = ritt_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ritt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ritt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [ritt_pkg::S_TDATA_W-1:0]    s_tdata,   // [30:0] value, [31] zero
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ritt_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] ch, [11:8] digit_count,
                                                         // [12] error, [15:13] zero
    input  logic                              m_tlast,   // last
    input  logic                              m_tuser,   // ch_valid
    output int                                fail_count,
    output int                                pending
);

    localparam int PAD_W     = ritt_pkg::M_TDATA_W - ritt_pkg::CH_W - ritt_pkg::COUNT_W - 1;
    localparam int DUE_DEPTH = 1024;
    localparam int DUE_IDX_W = $clog2(DUE_DEPTH);
    localparam logic [ritt_pkg::CH_W-1:0] DIGIT_ZERO = "0";
    localparam logic [ritt_pkg::CH_W-1:0] LETTER_A   = "A";

    typedef struct packed {
        logic [ritt_pkg::CH_W-1:0]    ch;
        logic                         ch_valid;
        logic                         last;
        logic [ritt_pkg::COUNT_W-1:0] count;
        logic                         err;
    } field_char_t;

    // expected characters in arrival order, kept as a ring
    field_char_t                     due_mem [DUE_DEPTH];
    logic [DUE_IDX_W-1:0]            due_wr;
    logic [DUE_IDX_W-1:0]            due_rd;
    int                              due_count;
    field_char_t                     want;
    logic [ritt_pkg::RADIX_W-1:0]    radix_reg;
    logic [ritt_pkg::FW_W-1:0]       width_reg;

    logic [ritt_pkg::CH_W-1:0]       got_ch;
    logic [ritt_pkg::COUNT_W-1:0]    got_count;
    logic                            got_err;
    logic [PAD_W-1:0]                got_pad;

    assign got_ch    = m_tdata[ritt_pkg::CH_W-1:0];
    assign got_count = m_tdata[ritt_pkg::CH_W +: ritt_pkg::COUNT_W];
    assign got_err   = m_tdata[ritt_pkg::CH_W + ritt_pkg::COUNT_W];
    assign got_pad   = m_tdata[ritt_pkg::M_TDATA_W-1 -: PAD_W];

    function automatic logic [ritt_pkg::CH_W-1:0] glyph(
        input logic [ritt_pkg::DIGIT_W-1:0] d
    );
        if (d < 4'd10) begin
            return DIGIT_ZERO + ritt_pkg::CH_W'(d);
        end
        return LETTER_A + ritt_pkg::CH_W'(d - 4'd10);
    endfunction

    task automatic due_put(input field_char_t c);
        due_mem[due_wr] = c;
        due_wr          = due_wr + 1'b1;
        due_count++;
    endtask

    task automatic due_take(output field_char_t c);
        c      = due_mem[due_rd];
        due_rd = due_rd + 1'b1;
        due_count--;
    endtask

    // right-justified digits, spaces to the left, nul in the final position
    task automatic render_field(input logic [ritt_pkg::VALUE_W-1:0] value_in);
        logic [ritt_pkg::CH_W-1:0]    text [MAX_WIDTH];
        logic [ritt_pkg::VALUE_W-1:0] rest;
        logic [ritt_pkg::COUNT_W-1:0] ndig;
        logic                         err;
        int                           w;
        field_char_t                  c;
        rest = value_in;
        ndig = '0;
        err  = 1'b0;
        if (width_reg == '0) begin
            c.ch       = ritt_pkg::CHAR_NUL;
            c.ch_valid = 1'b0;
            c.last     = 1'b1;
            c.count    = '0;
            c.err      = 1'b1;
            due_put(c);
        end else begin
            w = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            for (int j = 0; j < MAX_WIDTH; j++) text[j] = ritt_pkg::CHAR_SPACE;
            text[w-1] = ritt_pkg::CHAR_NUL;
            if (w > 1) begin
                if (radix_reg < ritt_pkg::RADIX_MIN || radix_reg > ritt_pkg::RADIX_MAX) begin
                    err = 1'b1;
                end else begin
                    for (int j = w - 2; j >= 0; j--) begin
                        if (rest != '0) begin
                            text[j] = glyph(ritt_pkg::DIGIT_W'(
                                          rest % ritt_pkg::VALUE_W'(radix_reg)));
                            rest    = rest / ritt_pkg::VALUE_W'(radix_reg);
                            ndig++;
                        end
                    end
                    if (rest != '0) err = 1'b1;
                end
            end
            for (int j = 0; j < w; j++) begin
                c.ch       = text[j];
                c.ch_valid = 1'b1;
                c.last     = (j == w - 1);
                c.count    = c.last ? ndig : '0;
                c.err      = c.last ? err : 1'b0;
                due_put(c);
            end
        end
    endtask

    task automatic log_failure(input bit have_want);
        fail_count++;
        if (fail_count <= 10) begin
            if (!have_want) begin
                $display("%0t: unexpected result item: ch %h valid %b last %b count %0d err %b",
                         $time, got_ch, m_tuser, m_tlast, got_count, got_err);
            end else begin
                $display("%0t: mismatch: expected ch %h valid %b last %b count %0d err %b",
                         $time, want.ch, want.ch_valid, want.last, want.count, want.err);
                $display("%0t:           got ch %h valid %b last %b count %0d err %b pad %b",
                         $time, got_ch, m_tuser, m_tlast, got_count, got_err, got_pad);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg = ritt_pkg::RADIX_RESET;
            width_reg = ritt_pkg::FW_RESET;
            due_wr    = '0;
            due_rd    = '0;
            due_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_count == 0) begin
                    log_failure(1'b0);
                end else begin
                    due_take(want);
                    if (got_ch !== want.ch || m_tuser !== want.ch_valid ||
                        m_tlast !== want.last || got_count !== want.count ||
                        got_err !== want.err || got_pad !== '0) begin
                        log_failure(1'b1);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    ritt_pkg::REG_RADIX:
                        radix_reg = cfg_wdata[ritt_pkg::RADIX_W-1:0];
                    ritt_pkg::REG_FIELD_WIDTH:
                        width_reg = cfg_wdata[ritt_pkg::FW_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                render_field(s_tdata[ritt_pkg::VALUE_W-1:0]);
            end
        end
        pending <= due_count;
    end

endmodule

// ===== sim/tb_radix_integer_to_text.sv =====
`timescale 1ns / 1ps
// top of the radix text converter testbench: clock, reset, register writes, input items
// and receiver back-pressure; depends on ritt_pkg, radix_integer_to_text, text_field_checker
module tb_radix_integer_to_text;

    localparam int MAX_WIDTH     = ritt_pkg::MAX_WIDTH_DEF;
    localparam int TAIL_CYCLES   = 2 * (MAX_WIDTH + 16);
    localparam int SETTLE_CYCLES = 8;
    localparam int SETS_PER_MODE = 8;
    localparam int ITEMS_PER_SET = 17;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [ritt_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [ritt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [ritt_pkg::S_TDATA_W-1:0]  s_tdata   = '0;  // [30:0] value, [31] zero
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [ritt_pkg::M_TDATA_W-1:0]  m_tdata;         // [7:0] ch, [11:8] digit_count, [12] error
    logic                            m_tlast;
    logic                            m_tuser;

    int mismatches;
    int pending;

    // percentages of cycles in which each side holds back
    int tx_idle_pct = 29;
    int rx_idle_pct = 76;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    radix_integer_to_text #(
        .MAX_WIDTH (MAX_WIDTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    text_field_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (mismatches),
        .pending    (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one input item: optional idle gap, then hold valid until taken
    // tready is sampled at the falling edge, well clear of the rising-edge updates
    task automatic send_value(input logic [ritt_pkg::VALUE_W-1:0] v);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ritt_pkg::S_TDATA_W'(v);
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
    endtask

    // sender holds off until every expected character has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ritt_pkg::CFG_ADDR_W-1:0] a,
                             input logic [ritt_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge aclk);
    endtask

    // registers only change while the converter is idle
    task automatic reconfigure(input logic [ritt_pkg::RADIX_W-1:0] r,
                               input logic [ritt_pkg::FW_W-1:0] fw);
        wait_drained();
        write_reg(ritt_pkg::REG_RADIX, ritt_pkg::CFG_DATA_W'(r));
        write_reg(ritt_pkg::REG_FIELD_WIDTH, ritt_pkg::CFG_DATA_W'(fw));
        cfg_we <= 1'b0;
    endtask

    // mostly legal bases, now and then any byte
    function automatic logic [ritt_pkg::RADIX_W-1:0] random_radix();
        if ($urandom_range(9) < 8) return ritt_pkg::RADIX_W'($urandom_range(16, 2));
        return ritt_pkg::RADIX_W'($urandom_range(255, 0));
    endfunction

    // zero, one, saturating and full widths get their share
    function automatic logic [ritt_pkg::FW_W-1:0] random_width();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ritt_pkg::FW_W'(1);
            2:       return ritt_pkg::FW_W'($urandom_range(31, MAX_WIDTH + 1));
            3:       return ritt_pkg::FW_W'(MAX_WIDTH);
            default: return ritt_pkg::FW_W'($urandom_range(MAX_WIDTH, 2));
        endcase
    endfunction

    // random bit length so short values fit and long ones overflow
    function automatic logic [ritt_pkg::VALUE_W-1:0] random_value();
        logic [31:0] raw;
        int          nbits;
        raw = $urandom;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return raw[ritt_pkg::VALUE_W-1:0];
            default: begin
                nbits = $urandom_range(ritt_pkg::VALUE_W, 1);
                return ritt_pkg::VALUE_W'(raw >> (32 - nbits));
            end
        endcase
    endfunction

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: base ten, ten positions, so nine digits fit
        send_value(31'd0);
        send_value(31'd1);
        send_value(31'd123456789);
        send_value(31'd1000000000);
        send_value(31'h7FFFFFFF);

        // widest field in hex and in binary; in binary an exact fit and an overflow by one
        reconfigure(ritt_pkg::RADIX_MAX, ritt_pkg::FW_W'(MAX_WIDTH));
        send_value(31'h7FFFFFFF);
        send_value(31'h00ABCDEF);
        reconfigure(ritt_pkg::RADIX_MIN, ritt_pkg::FW_W'(MAX_WIDTH));
        send_value(31'h00007FFF);
        send_value(31'h00008000);
        send_value(31'h7FFFFFFF);

        // empty field gives a single empty item
        reconfigure(8'd16, 5'd0);
        send_value(31'h00001234);

        // one position holds only the nul, base ignored
        reconfigure(8'd10, 5'd1);
        send_value(31'd98765);

        // bases out of range: spaces with the error flag
        reconfigure(8'd1, 5'd8);
        send_value(31'd42);
        reconfigure(8'd0, 5'd5);
        send_value(31'd0);
        reconfigure(8'd17, 5'd5);
        send_value(31'd3);
        reconfigure(8'd255, 5'd5);
        send_value(31'd9);

        // width above the maximum saturates
        reconfigure(8'd8, 5'd31);
        send_value(31'o17777777777);
        reconfigure(8'd3, 5'd17);
        send_value(31'h55555555);

        // two positions: one digit then nul, or invalid base with a lone space
        reconfigure(8'd36, 5'd2);
        send_value(31'd7);
        reconfigure(8'd10, 5'd2);
        send_value(31'd5);
        send_value(31'd10);

        // random part in three back-pressure regimes
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 76;
                end
                1: begin
                    tx_idle_pct = 76;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < SETS_PER_MODE; k++) begin
                reconfigure(random_radix(), random_width());
                repeat (ITEMS_PER_SET) send_value(random_value());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
